// ===== hdl/ede_pkg.sv =====
// Shared constants, types and helpers of the edit distance engine.
`default_nettype none

package ede_pkg;

    // Longest target and longest candidate that are kept.
    localparam int MAX_LEN = 256;

    // Width of a DP value: it never exceeds MAX_LEN.
    localparam int DW = $clog2(MAX_LEN + 1);

    // In-flight item counter: the entry stage plus one stage per cell.
    localparam int CW = $clog2(MAX_LEN + 2);

    localparam int CH_W       = 8;
    localparam int THR_W      = 9;
    localparam int DIST_OUT_W = 9;
    localparam int DIST_OUT_MAX = (1 << DIST_OUT_W) - 1;

    localparam logic [THR_W-1:0] THR_RESET = 9'd2;

    typedef logic [DW-1:0] t_dist;
    typedef logic [DW:0]   t_sum;
    typedef logic [CW-1:0] t_count;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_TGT   = 2'd1,
        ACT_CAND  = 2'd2,
        ACT_END   = 2'd3
    } t_action;

    // One wavefront request travelling down the cell chain. For a candidate
    // character, d_new is the new value of the cell to the left and d_old its
    // previous value. For an end marker, d_new carries the distance so far.
    typedef struct packed {
        logic            valid;
        logic            last;
        logic [CH_W-1:0] ch;
        t_dist           d_new;
        t_dist           d_old;
        logic            ovf;
    } t_wave;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic            en;
        logic            clear;
        logic            load;
        t_dist           load_idx;
        logic [CH_W-1:0] load_ch;
    } t_cell_ctrl;

    // Clamp a distance to the width of the output field.
    function automatic logic [DIST_OUT_W-1:0] sat_dist(input t_dist d);
        int v;
        v = int'(d);
        if (v > DIST_OUT_MAX) begin
            v = DIST_OUT_MAX;
        end
        return DIST_OUT_W'(v);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ede_cell.sv =====
// One cell of the chain: holds one target character and one DP entry.
`default_nettype none

module ede_cell (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire ede_pkg::t_dist      i_index,
    input  wire ede_pkg::t_cell_ctrl i_ctrl,
    input  wire ede_pkg::t_wave      i_wave,
    output ede_pkg::t_wave           o_wave
);

    logic [ede_pkg::CH_W-1:0] r_tch, n_tch;
    logic                     r_tvld, n_tvld;
    ede_pkg::t_dist           r_d, n_d;
    ede_pkg::t_wave           r_wave, n_wave;

    ede_pkg::t_sum up1, left1, diag1, m;
    logic          mism;

    // A cell past the end of the target always counts as a mismatch; its
    // value is never read as a result.
    always_comb begin
        mism  = !r_tvld || (r_tch != i_wave.ch);
        up1   = {1'b0, r_d} + ede_pkg::t_sum'(1);
        left1 = {1'b0, i_wave.d_new} + ede_pkg::t_sum'(1);
        diag1 = {1'b0, i_wave.d_old} + ede_pkg::t_sum'(mism);
        m     = (up1 < left1) ? up1 : left1;
        m     = (m < diag1) ? m : diag1;
    end

    always_comb begin
        n_d    = r_d;
        n_tvld = r_tvld;
        n_tch  = r_tch;
        n_wave = r_wave;
        if (i_ctrl.clear) begin
            n_tvld = 1'b0;
            n_d    = i_index;
        end else if (i_ctrl.load && (i_ctrl.load_idx == i_index)) begin
            n_tvld = 1'b1;
            n_tch  = i_ctrl.load_ch;
        end
        if (i_ctrl.en) begin
            n_wave = i_wave;
            if (i_wave.valid) begin
                if (i_wave.last) begin
                    // The end marker picks up this entry if it is part of the
                    // target, then the entry returns to its initial value.
                    n_d = i_index;
                    if (r_tvld) begin
                        n_wave.d_new = r_d;
                    end
                end else begin
                    n_d          = m[ede_pkg::DW-1:0];
                    n_wave.d_new = m[ede_pkg::DW-1:0];
                    n_wave.d_old = r_d;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvld       <= 1'b0;
            r_d          <= i_index;
            r_wave.valid <= 1'b0;
        end else begin
            r_tvld <= n_tvld;
            r_d    <= n_d;
            r_wave <= n_wave;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tch <= n_tch;
    end

    assign o_wave = r_wave;

endmodule

`default_nettype wire

// ===== hdl/edit_distance_engine.sv =====
// Top level of the edit distance engine: control, entry stage, cell chain, result register.
`default_nettype none

// Levenshtein distance between a stored target string and a streamed
// candidate, with insert, delete and substitute each costing one. Requests
// arrive on the slave side with the action in tuser and the character in
// tdata: clear target, append a target character, append a candidate
// character, or end the candidate. The target sits in a chain of MAX_LEN
// cells, one character and one DP entry per cell. Each candidate character
// enters the chain as a wavefront and moves one cell per clock, so a new
// candidate character or end request is taken every cycle while no result
// is stalled. An end request follows the last character down the chain,
// collects the entry of the last target cell, restores each entry to its
// initial value behind it, and is registered in the entry stage, in every
// cell and in the result register before it appears as the result; the
// next candidate may follow it at once. Clear and target-append requests
// change the cells directly, so they wait until the chain is empty. A
// stalled result holds the whole chain. The user must write the threshold
// register only while the engine is idle; the engine does not enforce this.
// Characters past MAX_LEN are dropped and flagged as overflow in the result.
module edit_distance_engine (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Threshold register write.
    input  wire         i_cfg_wr_en,
    input  wire  [8:0]  i_cfg_wr_data,
    // Request channel.
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,   // [7:0] ch
    input  wire  [1:0]  i_s_tuser,   // [1:0] action
    // Result channel.
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [15:0] o_m_tdata    // [8:0] edit_distance, [9] within_threshold,
                                     // [10] overflow, [15:11] zero
);

    localparam int NCELL = ede_pkg::MAX_LEN;

    // Configuration and string state.
    logic [ede_pkg::THR_W-1:0] r_thr;
    ede_pkg::t_dist            r_tlen, n_tlen;
    ede_pkg::t_dist            r_clen, n_clen;
    logic                      r_ovf, n_ovf;
    logic                      r_tdrop, n_tdrop;
    ede_pkg::t_count           r_cnt, n_cnt;

    // Entry stage and the chain between cells.
    ede_pkg::t_wave            r_w0, n_w0;
    ede_pkg::t_wave            w_chain [NCELL+1];
    ede_pkg::t_cell_ctrl       cell_ctrl;

    // Result register.
    logic                           r_out_vld;
    logic [ede_pkg::DIST_OUT_W-1:0] r_out_dist;
    logic                           r_out_within;
    logic                           r_out_ovf;

    ede_pkg::t_action action;
    ede_pkg::t_wave   tail;
    logic             en;
    logic             acc;
    logic             inc, dec;

    assign action = ede_pkg::t_action'(i_s_tuser);
    assign tail   = w_chain[NCELL];

    // The chain moves whenever the result register can take what leaves it.
    assign en  = !r_out_vld || i_m_tready;
    assign acc = i_s_tvalid && o_s_tready;

    // Requests that touch the cells directly need an empty chain.
    always_comb begin
        unique case (action)
            ede_pkg::ACT_CLEAR, ede_pkg::ACT_TGT: o_s_tready = (r_cnt == '0);
            default:                              o_s_tready = en;
        endcase
    end

    // Request decoder: string lengths, overflow flags, cell control and the entry stage.
    always_comb begin
        n_tlen  = r_tlen;
        n_clen  = r_clen;
        n_ovf   = r_ovf;
        n_tdrop = r_tdrop;
        n_w0    = r_w0;
        n_w0.valid = 1'b0;
        n_w0.last  = 1'b0;

        cell_ctrl.en       = en;
        cell_ctrl.clear    = 1'b0;
        cell_ctrl.load     = 1'b0;
        cell_ctrl.load_idx = r_tlen + ede_pkg::t_dist'(1);
        cell_ctrl.load_ch  = i_s_tdata;

        if (acc) begin
            unique case (action)
                ede_pkg::ACT_CLEAR: begin
                    cell_ctrl.clear = 1'b1;
                    n_tlen  = '0;
                    n_clen  = '0;
                    n_ovf   = 1'b0;
                    n_tdrop = 1'b0;
                end
                ede_pkg::ACT_TGT: begin
                    // Target characters are ignored while a candidate is open.
                    if (r_clen == '0) begin
                        if (r_tlen >= ede_pkg::t_dist'(ede_pkg::MAX_LEN)) begin
                            n_ovf   = 1'b1;
                            n_tdrop = 1'b1;
                        end else begin
                            cell_ctrl.load = 1'b1;
                            n_tlen = r_tlen + ede_pkg::t_dist'(1);
                        end
                    end
                end
                ede_pkg::ACT_CAND: begin
                    if (r_clen >= ede_pkg::t_dist'(ede_pkg::MAX_LEN)) begin
                        n_ovf = 1'b1;
                    end else begin
                        // Boundary column entry: row zero is the candidate length.
                        n_w0.valid = 1'b1;
                        n_w0.ch    = i_s_tdata;
                        n_w0.d_new = r_clen + ede_pkg::t_dist'(1);
                        n_w0.d_old = r_clen;
                        n_clen     = r_clen + ede_pkg::t_dist'(1);
                    end
                end
                ede_pkg::ACT_END: begin
                    // With an empty target the distance is the candidate length.
                    n_w0.valid = 1'b1;
                    n_w0.last  = 1'b1;
                    n_w0.d_new = r_clen;
                    n_w0.ovf   = r_ovf;
                    n_clen     = '0;
                    n_ovf      = r_tdrop;
                end
                default: begin
                end
            endcase
        end
    end

    assign inc   = en && n_w0.valid;
    assign dec   = en && tail.valid;
    assign n_cnt = r_cnt + ede_pkg::t_count'(inc) - ede_pkg::t_count'(dec);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= ede_pkg::THR_RESET;
            r_tlen     <= '0;
            r_clen     <= '0;
            r_ovf      <= 1'b0;
            r_tdrop    <= 1'b0;
            r_cnt      <= '0;
            r_w0.valid <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end
            r_tlen  <= n_tlen;
            r_clen  <= n_clen;
            r_ovf   <= n_ovf;
            r_tdrop <= n_tdrop;
            r_cnt   <= n_cnt;
            if (en) begin
                r_w0      <= n_w0;
                r_out_vld <= tail.valid && tail.last;
            end
        end
    end

    // Result payload: only end markers leave the chain as results.
    always_ff @(posedge i_clk) begin
        if (en && tail.valid && tail.last) begin
            r_out_dist   <= ede_pkg::sat_dist(tail.d_new);
            r_out_within <= (int'(tail.d_new) <= int'(r_thr));
            r_out_ovf    <= tail.ovf;
        end
    end

    assign w_chain[0] = r_w0;

    for (genvar j = 1; j <= NCELL; j++) begin : g_cell
        ede_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (ede_pkg::t_dist'(j)),
            .i_ctrl  (cell_ctrl),
            .i_wave  (w_chain[j-1]),
            .o_wave  (w_chain[j])
        );
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {5'd0, r_out_ovf, r_out_within, r_out_dist};

`ifndef SYNTHESIS
    // Cells are never rewritten while a wavefront is in flight.
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (!cell_ctrl.load && !cell_ctrl.clear))
        else $error("target cells changed while the chain was busy");

    // A waiting result freezes the chain.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_m_tready) |-> !cell_ctrl.en)
        else $error("chain advanced while a result was stalled");

    // The in-flight count never exceeds the number of stages.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cnt) <= NCELL + 1)
        else $error("in-flight count out of range");

    // A result never reports more than the longest string.
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (int'(r_out_dist) <= ede_pkg::MAX_LEN))
        else $error("distance above the longest string");

    // A drained chain goes with an empty entry stage and an empty tail.
    a_empty_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (!r_w0.valid && !tail.valid))
        else $error("request in the chain while the count is zero");
`endif

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the edit distance engine, with directed and random request streams.
module testbench;

    // A wait long enough for an end request to pass the entry stage, every cell and the result register.
    // Clear and target requests may wait about as long for the chain to empty.
    localparam int CHAIN_LATENCY = ede_pkg::MAX_LEN + 4;
    // Longest legal stretch without any handshake is one chain drain plus
    // stalls on both sides. This limit leaves a wide margin above that.
    localparam int QUIET_LIMIT   = 8 * (ede_pkg::MAX_LEN + 40);
    localparam int RANDOM_ITEMS  = 450;
    localparam int PRINT_LIMIT   = 20;

    typedef logic [7:0] t_text [$];

    typedef struct {
        logic [8:0] distance;
        logic       close;
        logic       ovf;
    } t_score;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [8:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    // Both sides may idle at random until the final part of the run.
    bit idling_on = 1'b1;

    // Shadow of the engine: threshold, stored target and the DP column.
    int          thr_model;
    logic [7:0]  tgt_model [ede_pkg::MAX_LEN];
    int          tgt_len;
    int          cand_len;
    int          column [ede_pkg::MAX_LEN+1];
    bit          ovf_seen;
    bit          tgt_dropped;
    t_score      expected_scores [$];

    // Run statistics.
    int mismatch_count;
    int requests_sent;
    int results_checked;
    int close_matches;
    int overflow_results;
    int widest_distance;
    int thresholds_written;

    edit_distance_engine dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .o_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .o_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .o_m_tdata     (m_tdata)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Puts every DP entry back to its distance from the empty candidate.
    function automatic void restart_column();
        for (int i = 0; i <= ede_pkg::MAX_LEN; i++) begin
            column[i] = i;
        end
    endfunction

    // Advances the shadow engine by one accepted request. An end request
    // queues the score that the engine has to return for it.
    function automatic void update_distance_model(input ede_pkg::t_action act,
                                                  input logic [7:0] c);
        int     diag;
        int     up;
        int     best;
        int     cost;
        t_score s;
        case (act)
            ede_pkg::ACT_CLEAR: begin
                tgt_len     = 0;
                cand_len    = 0;
                ovf_seen    = 1'b0;
                tgt_dropped = 1'b0;
                restart_column();
            end
            ede_pkg::ACT_TGT: begin
                // A target character in the middle of a candidate is ignored.
                if (cand_len == 0) begin
                    if (tgt_len >= ede_pkg::MAX_LEN) begin
                        ovf_seen    = 1'b1;
                        tgt_dropped = 1'b1;
                    end else begin
                        tgt_model[tgt_len] = c;
                        tgt_len++;
                        column[tgt_len] = tgt_len;
                    end
                end
            end
            ede_pkg::ACT_CAND: begin
                if (cand_len >= ede_pkg::MAX_LEN) begin
                    ovf_seen = 1'b1;
                end else begin
                    diag      = column[0];
                    column[0] = cand_len + 1;
                    for (int i = 1; i <= tgt_len; i++) begin
                        up   = column[i];
                        best = up + 1;
                        if (column[i-1] + 1 < best) begin
                            best = column[i-1] + 1;
                        end
                        if (diag + ((tgt_model[i-1] == c) ? 0 : 1) < best) begin
                            best = diag + ((tgt_model[i-1] == c) ? 0 : 1);
                        end
                        column[i] = best;
                        diag      = up;
                    end
                    cand_len++;
                end
            end
            ede_pkg::ACT_END: begin
                cost       = column[tgt_len];
                s.distance = (cost > 511) ? 9'd511 : 9'(cost);
                s.close    = (cost <= thr_model);
                s.ovf      = ovf_seen;
                expected_scores.push_back(s);
                cand_len = 0;
                ovf_seen = tgt_dropped;
                restart_column();
            end
        endcase
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("Mismatch on result %0d: %s is %0d, expected %0d",
                     results_checked, field, got, want);
        end
    endtask

    // Sends one request, sometimes after a burst of idle cycles, and holds it
    // until the engine takes it. The shadow engine moves on at the handshake.
    task automatic send_request(input ede_pkg::t_action act, input logic [7:0] c);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 12);
        end
        if (gap > 0) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= c;
        do @(posedge clk); while (!s_tready);
        update_distance_model(act, c);
        requests_sent++;
    endtask

    task automatic drop_valid();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // The threshold is only written once the engine is idle: every score has
    // come back and the chain has had time to drain.
    task automatic set_threshold(input int v);
        drop_valid();
        while (expected_scores.size() != 0) @(posedge clk);
        repeat (CHAIN_LATENCY) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= 9'(v);
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        thr_model = v;
        thresholds_written++;
    endtask

    function automatic logic [7:0] pick_char();
        // Mostly a small alphabet so that characters often match.
        if ($urandom_range(0, 3) != 0) begin
            return 8'($urandom_range(97, 100));
        end
        return 8'($urandom);
    endfunction

    function automatic t_text random_word(input int len);
        t_text w;
        for (int i = 0; i < len; i++) begin
            w.push_back(pick_char());
        end
        return w;
    endfunction

    task automatic load_target(input t_text w);
        foreach (w[i]) begin
            send_request(ede_pkg::ACT_TGT, w[i]);
        end
    endtask

    // Streams a candidate and closes it with an end request. With noise on,
    // a random request of any kind is sometimes slipped in between characters.
    task automatic send_candidate(input t_text w, input bit noise);
        foreach (w[i]) begin
            send_request(ede_pkg::ACT_CAND, w[i]);
            if (noise && $urandom_range(0, 19) == 0) begin
                send_request(ede_pkg::t_action'($urandom_range(0, 3)), 8'($urandom));
            end
        end
        send_request(ede_pkg::ACT_END, 8'($urandom));
    endtask

    // Empty target and empty candidate in every combination, with the
    // extreme character codes loaded into the target.
    task automatic test_empty_strings();
        send_request(ede_pkg::ACT_END, 8'($urandom));
        send_candidate('{8'h61, 8'h62}, 1'b0);
        load_target('{8'h00, 8'hFF, 8'h41});
        send_request(ede_pkg::ACT_END, 8'($urandom));
    endtask

    // Exact match, the first two codes swapped with the last one dropped, and a substitution against the extreme codes.
    task automatic test_char_extremes();
        send_candidate('{8'h00, 8'hFF, 8'h41}, 1'b0);
        send_candidate('{8'hFF, 8'h00}, 1'b0);
        send_candidate('{8'h00, 8'hFE, 8'h41}, 1'b0);
    endtask

    // A target character inside a candidate is ignored, and a clear in the
    // middle of a candidate empties both strings.
    task automatic test_append_rules();
        send_request(ede_pkg::ACT_CAND, 8'h41);
        send_request(ede_pkg::ACT_TGT, 8'h55);
        send_request(ede_pkg::ACT_CAND, 8'h42);
        send_request(ede_pkg::ACT_END, 8'($urandom));
        send_request(ede_pkg::ACT_CAND, 8'h12);
        send_request(ede_pkg::ACT_CLEAR, 8'($urandom));
        send_request(ede_pkg::ACT_END, 8'($urandom));
    endtask

    // Full-length strings: candidate overflow, the widest distance, target
    // overflow that sticks across candidates, and the threshold extremes.
    task automatic test_long_strings();
        t_text w;
        set_threshold(256);
        send_request(ede_pkg::ACT_CLEAR, 8'($urandom));
        w = random_word(ede_pkg::MAX_LEN);
        load_target(w);
        w.push_back(8'($urandom));
        send_candidate(w, 1'b0);
        send_request(ede_pkg::ACT_END, 8'($urandom));
        send_request(ede_pkg::ACT_TGT, 8'($urandom));
        send_request(ede_pkg::ACT_END, 8'($urandom));
        send_request(ede_pkg::ACT_END, 8'($urandom));
        set_threshold(255);
        send_request(ede_pkg::ACT_END, 8'($urandom));
        send_request(ede_pkg::ACT_CLEAR, 8'($urandom));
        send_request(ede_pkg::ACT_END, 8'($urandom));
    endtask

    // Phases of short words appended to the target, mostly after a clear, each followed by a few
    // candidates made from the word by random edits, under a fresh threshold per phase.
    task automatic test_random_matching();
        t_text word;
        t_text cand;
        int    start;
        int    phase;
        int    thr;
        start = requests_sent;
        phase = 0;
        while (requests_sent - start < RANDOM_ITEMS) begin
            if (requests_sent - start > RANDOM_ITEMS * 4 / 5) begin
                idling_on = 1'b0;
            end
            case ($urandom_range(0, 5))
                0:       thr = 0;
                1:       thr = 256;
                2:       thr = 1;
                3:       thr = 2;
                default: thr = $urandom_range(0, 256);
            endcase
            set_threshold((phase == 0) ? 0 : thr);
            if ($urandom_range(0, 3) != 0) begin
                send_request(ede_pkg::ACT_CLEAR, 8'($urandom));
            end
            word = random_word($urandom_range(0, 10));
            load_target(word);
            repeat ($urandom_range(1, 4)) begin
                cand = word;
                repeat ($urandom_range(0, 3)) begin
                    case ($urandom_range(0, 2))
                        0: cand.insert($urandom_range(0, cand.size()), pick_char());
                        1: if (cand.size() > 0) cand.delete($urandom_range(0, cand.size() - 1));
                        default: begin
                            if (cand.size() > 0) begin
                                cand[$urandom_range(0, cand.size() - 1)] = pick_char();
                            end
                        end
                    endcase
                end
                send_candidate(cand, 1'b1);
            end
            phase++;
        end
    endtask

    // Result sink: ready drops in random bursts while idling is on.
    initial begin : result_sink
        int hold;
        hold     = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold == 0 && idling_on && $urandom_range(0, 9) == 0) begin
                hold = $urandom_range(1, 12);
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Every accepted result is compared with the oldest queued score.
    always @(posedge clk) begin : score_check
        t_score want;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_scores.size() == 0) begin
                report_mismatch("unexpected result, tdata", m_tdata, 0);
            end else begin
                want = expected_scores.pop_front();
                if (m_tdata[8:0] !== want.distance) begin
                    report_mismatch("edit_distance", m_tdata[8:0], want.distance);
                end
                if (m_tdata[9] !== want.close) begin
                    report_mismatch("within_threshold", m_tdata[9], want.close);
                end
                if (m_tdata[10] !== want.ovf) begin
                    report_mismatch("overflow", m_tdata[10], want.ovf);
                end
                if (m_tdata[15:11] !== 5'd0) begin
                    report_mismatch("padding bits", m_tdata[15:11], 0);
                end
                close_matches    += want.close;
                overflow_results += want.ovf;
                if (want.distance > widest_distance) begin
                    widest_distance = want.distance;
                end
            end
            results_checked++;
        end
    end

    // Watchdog: too many cycles in a row without any handshake ends the run.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 9'd0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'd0;
        s_tuser     = ede_pkg::ACT_CLEAR;

        thr_model   = ede_pkg::THR_RESET;
        tgt_len     = 0;
        cand_len    = 0;
        ovf_seen    = 1'b0;
        tgt_dropped = 1'b0;
        restart_column();

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_strings();
        test_char_extremes();
        test_append_rules();
        test_long_strings();
        test_random_matching();

        // Drain: wait for every score, then for the chain to settle.
        drop_valid();
        while (expected_scores.size() != 0) @(posedge clk);
        repeat (CHAIN_LATENCY) @(posedge clk);

        $display("Sent %0d requests and checked %0d scores under %0d threshold settings.",
                 requests_sent, results_checked, thresholds_written);
        $display("Close matches %0d, overflow scores %0d, widest distance %0d.",
                 close_matches, overflow_results, widest_distance);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== edit_distance_engine.f =====
hdl/ede_pkg.sv
hdl/ede_cell.sv
hdl/edit_distance_engine.sv
verif/testbench.sv
